// File: rtl/hng_pkg.sv
// shared types and constants for the hysteresis noise gate
// no dependencies; used by hng_mul and hysteresis_noise_gate_unit
package hng_pkg;

	// threshold register and gain readout widths
	localparam int THR_W      = 21;
	localparam int GAIN_OUT_W = 21;
	localparam logic [THR_W-1:0] THR_RESET = 21'd46714;

	// shared multiplier geometry: a is taken in two 32-bit chunks
	localparam int MUL_A_W     = 64;
	localparam int MUL_B_W     = 32;
	localparam int MUL_CHUNK   = 32;
	localparam int MUL_P_W     = 64;
	localparam int MUL_ACC_W   = 96;
	localparam int COEF_SHIFT  = 32;

	// rate coefficients, unsigned Q0.32 rounded to nearest
	localparam logic [MUL_B_W-1:0] K_ATTACK  = 32'd343597384;
	localparam logic [MUL_B_W-1:0] K_RELEASE = 32'd1073742;
	localparam logic [MUL_B_W-1:0] K_RISE    = 32'd10737418;
	localparam logic [MUL_B_W-1:0] K_FALL    = 32'd2147484;
	localparam logic [MUL_B_W-1:0] K_HYST    = 32'd1932735283;

	// which rounding shift the multiplier applies
	typedef enum logic {
		SHIFT_COEF,
		SHIFT_OUT
	} mul_shift_t;

	// multiply request from the sequencer
	typedef struct packed {
		logic                 start;
		mul_shift_t           shift_sel;
		logic [MUL_A_W-1:0]   a;
		logic [MUL_B_W-1:0]   b;
	} mul_req_t;

	// multiply response back to the sequencer
	typedef struct packed {
		logic                 done;
		logic [MUL_A_W-1:0]   result;
	} mul_rsp_t;

endpackage

// File: rtl/hysteresis_noise_gate_unit.sv
// top level of the hysteresis noise gate, one audio sample per request
// depends on hng_pkg and hng_mul
//
// Noise gate for one channel of Q3.(SAMPLE_BITS-4) audio. A peak envelope
// follower tracks the sample magnitude; the gate opens when the envelope rises
// above the threshold register and closes when it falls below 0.45 of it, and
// the gain slews toward unity or zero. The output is the sample times the gain,
// rounded and saturated. Writing zero to the threshold bypasses the gate and
// skips the arithmetic; otherwise four products go one after another through a
// single shared 32x32 multiplier, and a new sample is taken only once the
// previous one has reached the output register. A result that cannot leave
// because the previous one still waits holds the sequencer until the output
// frees. The next request is taken while a result still waits in the output
// register.
module hysteresis_noise_gate_unit #(
	parameter int SAMPLE_BITS         = 24,
	parameter int EXTRA_FRACTION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// threshold register
	input  logic                             cfg_wr_en,
	input  logic [hng_pkg::THR_W-1:0]        cfg_wr_data,
	// sample in
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_BITS-1:0]    in_sample,
	// result out
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [SAMPLE_BITS-1:0]    out_sample,
	output logic                             gate_open,
	output logic [hng_pkg::GAIN_OUT_W-1:0]   gain_level
);

	localparam int FRAC_BITS = SAMPLE_BITS - 4;
	localparam int STATE_SH  = FRAC_BITS + EXTRA_FRACTION_BITS;
	localparam int ENV_W     = SAMPLE_BITS + EXTRA_FRACTION_BITS;
	localparam int GAIN_W    = STATE_SH + 1;
	localparam int THR_EXT_W = hng_pkg::THR_W + EXTRA_FRACTION_BITS;

	localparam logic [GAIN_W-1:0] UNITY = {1'b1, {STATE_SH{1'b0}}};
	localparam logic [hng_pkg::MUL_A_W-1:0] POS_LIM =
		(hng_pkg::MUL_A_W'(1) << (SAMPLE_BITS - 1)) - hng_pkg::MUL_A_W'(1);
	localparam logic [hng_pkg::MUL_A_W-1:0] NEG_LIM =
		hng_pkg::MUL_A_W'(1) << (SAMPLE_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HYST,
		ST_ENV,
		ST_GATE,
		ST_GAIN,
		ST_OUTM,
		ST_FIN,
		ST_WRITE
	} state_t;

	state_t                        state_q;
	logic                          go_q;
	logic [hng_pkg::THR_W-1:0]     thr_q;
	logic [ENV_W-1:0]              env_q;
	logic [GAIN_W-1:0]             gain_q;
	logic                          open_q;
	logic [THR_EXT_W-1:0]          hyst_q;
	logic                          neg_q;
	logic [SAMPLE_BITS-1:0]        mag_q;
	logic [SAMPLE_BITS-1:0]        om_q;
	logic [SAMPLE_BITS-1:0]        res_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_sample_q;
	logic                          gate_open_q;
	logic [hng_pkg::GAIN_OUT_W-1:0] gain_level_q;

	logic [SAMPLE_BITS-1:0]        raw;
	logic [SAMPLE_BITS-1:0]        mag_d;
	logic [ENV_W-1:0]              mag_ext;
	logic [THR_EXT_W-1:0]          thr_ext;
	logic                          env_up;
	logic [ENV_W-1:0]              env_diff;
	logic [GAIN_W-1:0]             gain_diff;
	logic [hng_pkg::MUL_A_W-1:0]   om_lim;
	logic [hng_pkg::MUL_A_W-1:0]   gain_wide;
	hng_pkg::mul_req_t             mul_req;
	hng_pkg::mul_rsp_t             mul_rsp;

	// magnitude of the incoming sample; the most negative value maps to 2^(n-1)
	assign raw   = in_sample;
	assign mag_d = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

	// envelope step direction and size
	assign mag_ext  = {mag_q, {EXTRA_FRACTION_BITS{1'b0}}};
	assign thr_ext  = {thr_q, {EXTRA_FRACTION_BITS{1'b0}}};
	assign env_up   = mag_ext > env_q;
	assign env_diff = env_up ? (mag_ext - env_q) : (env_q - mag_ext);

	// gain step size toward unity or zero
	assign gain_diff = open_q ? (UNITY - gain_q) : gain_q;

	// saturation bound for the output magnitude
	assign om_lim = neg_q ? NEG_LIM : POS_LIM;

	// gain readout in Q1.(SAMPLE_BITS-4)
	assign gain_wide = hng_pkg::MUL_A_W'(gain_q) >> EXTRA_FRACTION_BITS;

	// operand selection for the shared multiplier
	always_comb begin
		mul_req.start     = go_q;
		mul_req.shift_sel = hng_pkg::SHIFT_COEF;
		mul_req.a         = '0;
		mul_req.b         = '0;
		case (state_q)
			ST_HYST: begin
				mul_req.a = hng_pkg::MUL_A_W'(thr_ext);
				mul_req.b = hng_pkg::K_HYST;
			end
			ST_ENV: begin
				mul_req.a = hng_pkg::MUL_A_W'(env_diff);
				mul_req.b = env_up ? hng_pkg::K_ATTACK : hng_pkg::K_RELEASE;
			end
			ST_GAIN: begin
				mul_req.a = hng_pkg::MUL_A_W'(gain_diff);
				mul_req.b = open_q ? hng_pkg::K_RISE : hng_pkg::K_FALL;
			end
			ST_OUTM: begin
				mul_req.shift_sel = hng_pkg::SHIFT_OUT;
				mul_req.a         = hng_pkg::MUL_A_W'(gain_q);
				mul_req.b         = hng_pkg::MUL_B_W'(mag_q);
			end
			default: begin
				mul_req.a = '0;
			end
		endcase
	end

	hng_mul #(
		.OUT_SHIFT (STATE_SH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= hng_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// sequencer, gate state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			go_q         <= 1'b0;
			env_q        <= '0;
			gain_q       <= '0;
			open_q       <= 1'b0;
			hyst_q       <= '0;
			neg_q        <= 1'b0;
			mag_q        <= '0;
			om_q         <= '0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			gate_open_q  <= 1'b0;
			gain_level_q <= '0;
		end else begin
			go_q <= 1'b0;
			// the write step reloads the output itself
			if (out_valid_q && out_ready && state_q != ST_WRITE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q <= raw[SAMPLE_BITS-1];
						mag_q <= mag_d;
						if (thr_q == '0) begin
							// bypass: gate forced open at unity gain
							open_q  <= 1'b1;
							gain_q  <= UNITY;
							env_q   <= {mag_d, {EXTRA_FRACTION_BITS{1'b0}}};
							res_q   <= raw;
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_HYST;
							go_q    <= 1'b1;
						end
					end
				end
				ST_HYST: begin
					if (mul_rsp.done) begin
						hyst_q  <= THR_EXT_W'(mul_rsp.result);
						state_q <= ST_ENV;
						go_q    <= 1'b1;
					end
				end
				ST_ENV: begin
					if (mul_rsp.done) begin
						env_q   <= env_up ? (env_q + ENV_W'(mul_rsp.result))
						                  : (env_q - ENV_W'(mul_rsp.result));
						state_q <= ST_GATE;
					end
				end
				ST_GATE: begin
					// hysteresis: close below the lower level, open above the threshold
					if (open_q) begin
						if (env_q < ENV_W'(hyst_q)) begin
							open_q <= 1'b0;
						end
					end else if (env_q > ENV_W'(thr_ext)) begin
						open_q <= 1'b1;
					end
					state_q <= ST_GAIN;
					go_q    <= 1'b1;
				end
				ST_GAIN: begin
					if (mul_rsp.done) begin
						gain_q  <= open_q ? (gain_q + GAIN_W'(mul_rsp.result))
						                  : (gain_q - GAIN_W'(mul_rsp.result));
						state_q <= ST_OUTM;
						go_q    <= 1'b1;
					end
				end
				ST_OUTM: begin
					if (mul_rsp.done) begin
						om_q    <= (mul_rsp.result > om_lim) ? SAMPLE_BITS'(om_lim)
						                                     : SAMPLE_BITS'(mul_rsp.result);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_q   <= neg_q ? (~om_q + 1'b1) : om_q;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= res_q;
						gate_open_q  <= open_q;
						gain_level_q <= gain_wide[hng_pkg::GAIN_OUT_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign gate_open  = gate_open_q;
	assign gain_level = gain_level_q;

`ifndef SYNTH
	// gain slews toward its target and never passes unity
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY)
		else $error("gain above unity");

	// a zero threshold skips the arithmetic and opens the gate
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && thr_q == '0) |=> (state_q == ST_WRITE && open_q))
		else $error("bypass request not short-cut");

	// multiplier completions only arrive while the sequencer waits on one
	a_done_in_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_HYST || state_q == ST_ENV ||
		                  state_q == ST_GAIN || state_q == ST_OUTM))
		else $error("multiply completion outside a multiply step");

	// a pending result is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_sample_q))
		else $error("pending result overwritten");
`endif

endmodule

// File: rtl/hng_mul.sv
// shared multi-cycle multiplier with round-to-nearest right shift
// depends on hng_pkg; one 32x32 multiplier used over two chunks of a
module hng_mul #(
	parameter int OUT_SHIFT = 36
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hng_pkg::mul_req_t req,
	output hng_pkg::mul_rsp_t rsp
);

	localparam logic [1:0] CNT_LAST = 2'd2;
	localparam logic [hng_pkg::MUL_ACC_W-1:0] RND_COEF =
		hng_pkg::MUL_ACC_W'(1) << (hng_pkg::COEF_SHIFT - 1);
	localparam logic [hng_pkg::MUL_ACC_W-1:0] RND_OUT =
		hng_pkg::MUL_ACC_W'(1) << (OUT_SHIFT - 1);

	logic [hng_pkg::MUL_A_W-1:0]   a_q;
	logic [hng_pkg::MUL_B_W-1:0]   b_q;
	hng_pkg::mul_shift_t           shift_sel_q;
	logic                          busy_q;
	logic                          done_q;
	logic [1:0]                    cnt_q;
	logic [hng_pkg::MUL_P_W-1:0]   prod_q;
	logic [hng_pkg::MUL_ACC_W-1:0] acc_q;

	logic [hng_pkg::MUL_CHUNK-1:0] a_chunk;
	logic [hng_pkg::MUL_P_W-1:0]   prod_d;
	logic [hng_pkg::MUL_ACC_W-1:0] add_term;
	logic [hng_pkg::MUL_ACC_W-1:0] acc_shifted;

	// low chunk first, then high chunk
	assign a_chunk = (cnt_q == 2'd0) ? a_q[hng_pkg::MUL_CHUNK-1:0]
	                                 : a_q[hng_pkg::MUL_A_W-1:hng_pkg::MUL_CHUNK];
	assign prod_d  = a_chunk * b_q;

	// high partial product lands one chunk up
	assign add_term = (cnt_q == CNT_LAST)
		? {prod_q, {hng_pkg::MUL_CHUNK{1'b0}}}
		: {{hng_pkg::MUL_CHUNK{1'b0}}, prod_q};

	// final rounding shift
	assign acc_shifted = (shift_sel_q == hng_pkg::SHIFT_OUT) ? (acc_q >> OUT_SHIFT)
	                                                         : (acc_q >> hng_pkg::COEF_SHIFT);

	assign rsp.done   = done_q;
	assign rsp.result = acc_shifted[hng_pkg::MUL_A_W-1:0];

	// sequencing of the two partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// operand latch, product register and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q         <= req.a;
			b_q         <= req.b;
			shift_sel_q <= req.shift_sel;
			acc_q       <= (req.shift_sel == hng_pkg::SHIFT_OUT) ? RND_OUT : RND_COEF;
		end else if (busy_q) begin
			prod_q <= prod_d;
			if (cnt_q != 2'd0) begin
				acc_q <= acc_q + add_term;
			end
		end
	end

`ifndef SYNTH
	// a new request never lands on a multiply in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiply request while busy");

	// completion follows the last partial product
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == CNT_LAST && !req.start) |=> (done_q && !busy_q))
		else $error("multiply did not complete");
`endif

endmodule
